// ===== hdl/arp_pkg.sv =====
// Shared types, constants and the ticks-per-step table for the arpeggiator.
// No dependencies; every other file in hdl/ but arp_note_ram uses this package.
package arp_pkg;

  localparam int NOTE_SLOTS = 16;
  localparam int SLOT_AW    = $clog2(NOTE_SLOTS);
  localparam int CNT_W      = $clog2(NOTE_SLOTS + 1);
  localparam int SP_W       = CNT_W + 1;
  localparam int MOD_W      = (CNT_W > 4) ? CNT_W : 4;
  localparam int ENTRY_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CMD_W      = 3;

  localparam logic [6:0] PEDAL_CC = 7'd64;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_START    = 3'd1,
    CMD_CONTINUE = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_NOTE_ON  = 3'd4,
    CMD_NOTE_OFF = 3'd5,
    CMD_CC       = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_CHANNEL  = 3'd0,
    CFG_DIR      = 3'd1,
    CFG_SPAN     = 3'd2,
    CFG_RHYTHM   = 3'd3,
    CFG_DIVISION = 3'd4,
    CFG_GATE     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_UP     = 2'd0,
    DIR_DOWN   = 2'd1,
    DIR_UPDOWN = 2'd2,
    DIR_RANDOM = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    SOP_ON    = 2'd0,
    SOP_OFF   = 2'd1,
    SOP_CLEAR = 2'd2,
    SOP_READ  = 2'd3
  } store_op_t;

  typedef struct packed {
    logic               valid;
    store_op_t          op;
    logic [6:0]         key;
    logic [6:0]         vel;
    logic [SLOT_AW-1:0] addr;
  } store_req_t;

  typedef struct packed {
    logic               done;
    logic [ENTRY_W-1:0] entry;
  } store_rsp_t;

  typedef struct packed {
    logic       restart;
    logic       restart_down;
    logic       step;
    logic [7:0] rnd;
  } walk_cmd_t;

  function automatic logic [7:0] step_ticks(input logic [4:0] idx);
    logic [7:0] t;
    case (idx)
      5'd0:    t = 8'd192;
      5'd1:    t = 8'd144;
      5'd2:    t = 8'd96;
      5'd3:    t = 8'd72;
      5'd4:    t = 8'd64;
      5'd5:    t = 8'd48;
      5'd6:    t = 8'd36;
      5'd7:    t = 8'd32;
      5'd8:    t = 8'd24;
      5'd9:    t = 8'd16;
      5'd10:   t = 8'd12;
      5'd11:   t = 8'd8;
      5'd12:   t = 8'd6;
      5'd13:   t = 8'd4;
      5'd14:   t = 8'd3;
      5'd15:   t = 8'd2;
      default: t = 8'd1;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/arp_note_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependency.
module arp_note_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/arp_note_store.sv =====
// Pitch-sorted held-note store: scan/insert/delete sequencer over the note RAM.
// Depends on arp_pkg and arp_note_ram.
module arp_note_store (
  input  logic                        clk,
  input  logic                        rst,
  input  arp_pkg::store_req_t         req,
  output arp_pkg::store_rsp_t         rsp,
  output logic [arp_pkg::CNT_W-1:0]   count
);
  import arp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_FINISH = 5'b01000,
    S_DONE   = 5'b10000
  } st_t;

  st_t              state, state_next;
  logic [CNT_W-1:0] count_next;
  store_op_t        op, op_next;
  logic [6:0]       key, key_next, vel, vel_next;
  logic [CNT_W-1:0] idx, idx_next, idx_m1;
  logic [ENTRY_W-1:0] carry, carry_next;
  logic             carrying, carrying_next, found, found_next;

  logic               we, re;
  logic [SLOT_AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               has_room;
  logic [6:0]         rd_note;

  arp_note_ram #(.DEPTH(NOTE_SLOTS), .WIDTH(ENTRY_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign has_room = count < CNT_W'(NOTE_SLOTS);
  assign rd_note  = rdata[13:7];
  assign idx_m1   = idx - CNT_W'(1);

  always_comb begin
    state_next    = state;
    count_next    = count;
    op_next       = op;
    key_next      = key;
    vel_next      = vel;
    idx_next      = idx;
    carry_next    = carry;
    carrying_next = carrying;
    found_next    = found;
    we    = 1'b0;
    waddr = '0;
    wdata = carry;
    re    = 1'b0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next       = req.op;
          key_next      = req.key;
          vel_next      = req.vel;
          idx_next      = '0;
          carry_next    = {req.key, req.vel};
          carrying_next = 1'b0;
          found_next    = 1'b0;
          case (req.op)
            SOP_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            SOP_READ: begin
              re         = 1'b1;
              raddr      = req.addr;
              state_next = S_DONE;
            end
            default: state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (idx == count) begin
          state_next = S_FINISH;
        end else begin
          re         = 1'b1;
          raddr      = idx[SLOT_AW-1:0];
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_next   = idx + CNT_W'(1);
        state_next = S_SCAN;
        if (op == SOP_ON) begin
          if (rd_note == key) begin
            // repeat key: velocity only
            we         = 1'b1;
            waddr      = idx[SLOT_AW-1:0];
            wdata      = {key, vel};
            state_next = S_DONE;
          end else if (has_room && (carrying || rd_note > key)) begin
            // ripple entries up by one, carrying the displaced one
            we            = 1'b1;
            waddr         = idx[SLOT_AW-1:0];
            wdata         = carry;
            carry_next    = rdata;
            carrying_next = 1'b1;
          end
        end else begin
          if (found) begin
            we    = 1'b1;
            waddr = idx_m1[SLOT_AW-1:0];
            wdata = rdata;
          end else if (rd_note == key) begin
            found_next = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (op == SOP_ON && has_room) begin
          we         = 1'b1;
          waddr      = count[SLOT_AW-1:0];
          wdata      = carry;
          count_next = count + CNT_W'(1);
        end else if (op == SOP_OFF && found) begin
          count_next = count - CNT_W'(1);
        end
        state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    key      <= key_next;
    vel      <= vel_next;
    idx      <= idx_next;
    carry    <= carry_next;
    carrying <= carrying_next;
    found    <= found_next;
  end

  assign rsp.done  = (state == S_DONE);
  assign rsp.entry = rdata;

endmodule

// ===== hdl/arp_walker.sv =====
// Step/octave walk: up, down, up-down and random selection with a
// subtract-per-cycle remainder unit. Depends on arp_pkg.
module arp_walker (
  input  logic                       clk,
  input  logic                       rst,
  input  arp_pkg::walk_cmd_t         cmd,
  input  arp_pkg::dir_t              mode,
  input  logic [2:0]                 span,
  input  logic [arp_pkg::CNT_W-1:0]  count,
  output logic                       done,
  output logic [arp_pkg::SP_W-1:0]   step_pos,
  output logic [2:0]                 oct_pos
);
  import arp_pkg::*;

  typedef enum logic [4:0] {
    W_IDLE     = 5'b00001,
    W_AGAIN    = 5'b00010,
    W_MOD_OCT  = 5'b00100,
    W_MOD_STEP = 5'b01000,
    W_DONE     = 5'b10000
  } wst_t;

  wst_t             state;
  logic             moving_down;
  logic [MOD_W-1:0] rem;
  logic [3:0]       rnd_hi;

  logic [SP_W-1:0]       down_sp;
  logic [2:0]            down_op;
  logic signed [SP_W:0]  sp_x, n_x;
  logic signed [3:0]     op_x, span_x;
  logic                  wrap, out_of_span;
  logic                  adv_md, adv_again;
  logic [SP_W-1:0]       adv_sp;
  logic [2:0]            adv_op;

  assign down_sp = {1'b0, count} - SP_W'(1);
  assign down_op = span - 3'd1;
  assign n_x     = $signed({2'b00, count});
  assign span_x  = $signed({1'b0, span});

  // one advance of the walk from the current position
  always_comb begin
    sp_x = moving_down ? $signed({step_pos[SP_W-1], step_pos}) - (SP_W+1)'(1)
                       : $signed({step_pos[SP_W-1], step_pos}) + (SP_W+1)'(1);
    wrap   = 1'b0;
    adv_sp = sp_x[SP_W-1:0];
    if (sp_x >= n_x) begin
      adv_sp = '0;
      wrap   = 1'b1;
    end else if (sp_x < 0) begin
      adv_sp = down_sp;
      wrap   = 1'b1;
    end
    op_x = moving_down ? $signed({1'b0, oct_pos}) - 4'sd1
                       : $signed({1'b0, oct_pos}) + 4'sd1;
    out_of_span = (op_x >= span_x) || (op_x < 0);
    adv_md    = moving_down;
    adv_op    = oct_pos;
    adv_again = 1'b0;
    if (wrap) begin
      adv_op = op_x[2:0];
      if (out_of_span) begin
        if (mode == DIR_UPDOWN) begin
          adv_md    = !moving_down;
          adv_again = (count > CNT_W'(1)) || (span > 3'd1);
        end
        adv_sp = adv_md ? down_sp : '0;
        adv_op = adv_md ? down_op : 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= W_IDLE;
      moving_down <= 1'b0;
      step_pos    <= '0;
      oct_pos     <= '0;
    end else begin
      case (state)
        W_IDLE: begin
          if (cmd.restart) begin
            moving_down <= cmd.restart_down;
            step_pos    <= cmd.restart_down ? down_sp : '0;
            oct_pos     <= cmd.restart_down ? down_op : 3'd0;
          end else if (cmd.step) begin
            if (mode == DIR_RANDOM) begin
              state <= W_MOD_OCT;
            end else begin
              moving_down <= adv_md;
              step_pos    <= adv_sp;
              oct_pos     <= adv_op;
              state       <= adv_again ? W_AGAIN : W_DONE;
            end
          end
        end
        W_AGAIN: begin
          moving_down <= adv_md;
          step_pos    <= adv_sp;
          oct_pos     <= adv_op;
          state       <= W_DONE;
        end
        W_MOD_OCT: begin
          if (rem < MOD_W'(span)) begin
            oct_pos <= rem[2:0];
            state   <= W_MOD_STEP;
          end
        end
        W_MOD_STEP: begin
          if (rem < MOD_W'(count)) begin
            step_pos <= SP_W'(rem);
            state    <= W_DONE;
          end
        end
        W_DONE:  state <= W_IDLE;
        default: state <= W_IDLE;
      endcase
    end
  end

  // remainder datapath: load, then subtract the divisor once per cycle
  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        rem    <= MOD_W'(cmd.rnd[3:0]);
        rnd_hi <= cmd.rnd[7:4];
      end
      W_MOD_OCT: begin
        if (rem >= MOD_W'(span)) begin
          rem <= rem - MOD_W'(span);
        end else begin
          rem <= MOD_W'(rnd_hi);
        end
      end
      W_MOD_STEP: begin
        if (rem >= MOD_W'(count)) begin
          rem <= rem - MOD_W'(count);
        end
      end
      default: rem <= rem;
    endcase
  end

  assign done = (state == W_DONE);

endmodule

// ===== hdl/midi_arpeggiator_sequencer.sv =====
// Top level of the MIDI arpeggiator: stream ports, config registers, clock
// prescaler, rhythm walk and output register. Depends on arp_pkg,
// arp_note_store and arp_walker.
//
//  channel  | direction | group                 | contents
//  ---------+-----------+-----------------------+------------------------------
//  input    | in        | s_axis_t*             | MIDI event / clock beat
//  result   | out       | m_axis_t*             | note-on beat
//  config   | in        | cfg_we/index/data     | register write, no read-back
//
// One input beat is taken at a time; tready is high only while idle.
// Clock/transport beats are only decoded; a playing tick reads the held note,
// loads the output register and steps the walk (advancing again at an up-down
// turn); random mode runs the remainder unit, one subtract per cycle. Note
// on/off scans the held notes: one RAM read and one compare/write per held note.
// A finished result sits in the output register; a further playing tick
// waits for it to drain. rst is synchronous and clears all control state.
module midi_arpeggiator_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] midi_channel, [10:4] key_number, [17:11] strike_level,
  // [24:18] controller_number, [31:25] controller_value, [39:32] pick_seed
  input  logic [arp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [2:0] cmd
  input  logic [arp_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [6:0] play_note, [13:7] play_velocity, [21:14] gate_ticks, [23:22] zero
  output logic [arp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import arp_pkg::*;

  typedef enum logic [5:0] {
    T_IDLE   = 6'b000001,
    T_DECODE = 6'b000010,
    T_STORE  = 6'b000100,
    T_READ   = 6'b001000,
    T_NOTE   = 6'b010000,
    T_WALK   = 6'b100000
  } tst_t;

  tst_t state;

  // config registers
  logic [3:0]  listen_channel;
  dir_t        direction_mode;
  logic [2:0]  octave_span;
  logic [15:0] rhythm_word;
  logic [4:0]  division_index;
  logic [4:0]  gate_index;

  // transport state
  logic [7:0]  tick_count;
  logic [15:0] step_mask;
  logic        running_flag;
  logic        pedal_hold;

  // captured beat
  logic [2:0] it_cmd;
  logic [3:0] it_chan;
  logic [6:0] it_key, it_vel, it_ccn, it_ccv;
  logic [7:0] it_rnd;

  // output register
  logic       out_valid;
  logic [6:0] out_note, out_vel;
  logic [7:0] out_gate;

  store_req_t       sreq;
  store_rsp_t       srsp;
  logic [CNT_W-1:0] held_count;
  walk_cmd_t        wcmd;
  logic             walk_done;
  logic [SP_W-1:0]  step_pos;
  logic [2:0]       oct_pos;

  logic [7:0]  prescale, tick_inc;
  logic [15:0] mask_shift;
  logic [2:0]  span_eff;
  logic        chan_hit, play, slot_free, cfg_dir_wr;
  logic [SLOT_AW-1:0] play_idx;
  logic [7:0]  note_raw, note_fold;
  logic [2:0]  fold_cnt;

  arp_note_store u_store (
    .clk(clk), .rst(rst), .req(sreq), .rsp(srsp), .count(held_count)
  );

  arp_walker u_walker (
    .clk(clk), .rst(rst), .cmd(wcmd), .mode(direction_mode), .span(span_eff),
    .count(held_count), .done(walk_done), .step_pos(step_pos), .oct_pos(oct_pos)
  );

  assign prescale   = step_ticks(division_index);
  assign tick_inc   = tick_count + 8'd1;
  assign mask_shift = (step_mask[15] == 1'b1 && step_mask[14:0] == 15'd0)
                      ? 16'd1 : {step_mask[14:0], 1'b0};
  assign span_eff   = (octave_span == 3'd0) ? 3'd1 : octave_span;
  assign chan_hit   = (it_chan == listen_channel);
  assign play       = (held_count != '0) && ((step_mask & rhythm_word) != 16'd0);
  assign slot_free  = !out_valid || m_axis_tready;
  assign cfg_dir_wr = cfg_we && (cfg_index == CFG_DIR);

  // out-of-range step reads entry 0
  assign play_idx = (!step_pos[SP_W-1] && (step_pos[CNT_W-1:0] < held_count))
                    ? step_pos[SLOT_AW-1:0] : '0;

  // note plus octaves, folded back under 128 in steps of twelve;
  // the number of steps comes from parallel threshold compares
  always_comb begin
    note_raw = {1'b0, srsp.entry[13:7]} + (8'(oct_pos) * 8'd12);
    fold_cnt = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if (note_raw > 8'(127 + 12 * k)) begin
        fold_cnt = fold_cnt + 3'd1;
      end
    end
    note_fold = note_raw - (8'(fold_cnt) * 8'd12);
  end

  // note store requests are single-cycle pulses from decode
  always_comb begin
    sreq.valid = 1'b0;
    sreq.op    = SOP_READ;
    sreq.key   = it_key;
    sreq.vel   = it_vel;
    sreq.addr  = play_idx;
    if (state == T_DECODE) begin
      case (it_cmd)
        CMD_TICK: begin
          sreq.valid = running_flag && (tick_inc >= prescale) && play;
          sreq.op    = SOP_READ;
        end
        CMD_NOTE_ON: begin
          sreq.valid = chan_hit;
          sreq.op    = SOP_ON;
        end
        CMD_NOTE_OFF: begin
          sreq.valid = chan_hit && !pedal_hold;
          sreq.op    = SOP_OFF;
        end
        CMD_CC: begin
          sreq.valid = chan_hit && (it_ccn == PEDAL_CC) && pedal_hold && (it_ccv == 7'd0);
          sreq.op    = SOP_CLEAR;
        end
        default: sreq.valid = 1'b0;
      endcase
    end
  end

  // walk restarts on a direction write or on start; steps after each note
  always_comb begin
    wcmd.restart      = cfg_dir_wr || (state == T_DECODE && it_cmd == CMD_START);
    wcmd.restart_down = cfg_dir_wr ? (cfg_data[1:0] == DIR_DOWN)
                                   : (direction_mode == DIR_DOWN);
    wcmd.step         = (state == T_NOTE) && slot_free;
    wcmd.rnd          = it_rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      listen_channel <= 4'd0;
      direction_mode <= DIR_UP;
      octave_span    <= 3'd1;
      rhythm_word    <= 16'hffff;
      division_index <= 5'd12;
      gate_index     <= 5'd14;
      tick_count     <= 8'd0;
      step_mask      <= 16'd1;
      running_flag   <= 1'b0;
      pedal_hold     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL:  listen_channel <= cfg_data[3:0];
          CFG_DIR:      direction_mode <= dir_t'(cfg_data[1:0]);
          CFG_SPAN:     octave_span    <= cfg_data[2:0];
          CFG_RHYTHM:   rhythm_word    <= cfg_data;
          CFG_DIVISION: division_index <= cfg_data[4:0];
          CFG_GATE:     gate_index     <= cfg_data[4:0];
          default:      ;
        endcase
      end
      // a new note loaded in the same cycle keeps the register full
      if (m_axis_tvalid && m_axis_tready && !(state == T_NOTE && slot_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            state <= T_DECODE;
          end
        end
        T_DECODE: begin
          case (it_cmd)
            CMD_TICK: begin
              if (running_flag && (tick_inc >= prescale) && play) begin
                state <= T_READ;
              end else begin
                state <= T_IDLE;
              end
              if (running_flag) begin
                if (tick_inc >= prescale) begin
                  tick_count <= 8'd0;
                  step_mask  <= mask_shift;
                end else begin
                  tick_count <= tick_inc;
                end
              end
            end
            CMD_START: begin
              state        <= T_IDLE;
              running_flag <= 1'b1;
              step_mask    <= 16'd1;
              tick_count   <= prescale - 8'd1;
            end
            CMD_CONTINUE: begin
              state        <= T_IDLE;
              running_flag <= 1'b1;
            end
            CMD_STOP: begin
              state        <= T_IDLE;
              running_flag <= 1'b0;
            end
            CMD_NOTE_ON: begin
              state <= chan_hit ? T_STORE : T_IDLE;
            end
            CMD_NOTE_OFF: begin
              state <= (chan_hit && !pedal_hold) ? T_STORE : T_IDLE;
            end
            CMD_CC: begin
              state <= (chan_hit && it_ccn == PEDAL_CC && pedal_hold && it_ccv == 7'd0)
                       ? T_STORE : T_IDLE;
              if (chan_hit && it_ccn == PEDAL_CC) begin
                pedal_hold <= (it_ccv != 7'd0);
              end
            end
            default: state <= T_IDLE;
          endcase
        end
        T_STORE: begin
          if (srsp.done) begin
            state <= T_IDLE;
          end
        end
        T_READ: begin
          if (srsp.done) begin
            state <= T_NOTE;
          end
        end
        T_NOTE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= T_WALK;
          end
        end
        T_WALK: begin
          if (walk_done) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == T_IDLE && s_axis_tvalid) begin
      it_cmd  <= s_axis_tuser;
      it_chan <= s_axis_tdata[3:0];
      it_key  <= s_axis_tdata[10:4];
      it_vel  <= s_axis_tdata[17:11];
      it_ccn  <= s_axis_tdata[24:18];
      it_ccv  <= s_axis_tdata[31:25];
      it_rnd  <= s_axis_tdata[39:32];
    end
    if (state == T_NOTE && slot_free) begin
      out_note <= note_fold[6:0];
      out_vel  <= srsp.entry[6:0];
      out_gate <= step_ticks(gate_index) - 8'd1;
    end
  end

  assign s_axis_tready = (state == T_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_gate, out_vel, out_note};

endmodule

// ===== hdl/arp_checker.sv =====
// Port-level checks for the arpeggiator top, attached by bind.
// Depends on arp_pkg and midi_arpeggiator_sequencer.
module arp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [arp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one beat at a time: busy right after an accept
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken before decode");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // gate length comes from the table minus one, never above 191
  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[21:14] <= 8'd191) && (m_axis_tdata[23:22] == 2'b00))
    else $error("gate field out of range");

endmodule

bind midi_arpeggiator_sequencer arp_checker u_arp_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for midi_arpeggiator_sequencer: directed table, then
// randomized phases with idling, stalls and a long receiver hold-off.
// Depends on arp_pkg and the RTL in hdl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [7:0] gate;
    logic [6:0] vel;
    logic [6:0] note;
  } note_beat_t;

  typedef struct {
    logic [2:0] cmd;
    logic [3:0] chan;
    logic [6:0] key;
    logic [6:0] vel;
    logic [6:0] ccn;
    logic [6:0] ccv;
    logic [7:0] rnd;
    bit         typed;      // expected note-on given in the row
    note_beat_t want;
  } midi_row_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  midi_arpeggiator_sequencer u_top (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Arpeggiator predictor: own copy of registers and note stack
  // ---------------------------------------------------------------------------
  int unsigned reg_chan, reg_dir, reg_span, reg_rhythm, reg_div, reg_gate;
  logic [13:0] stack_q [NOTE_SLOTS];
  int          stack_n;
  logic [7:0]  prescale_cnt;
  logic [15:0] rhythm_bit;
  bit          playing, walk_down, sustain;
  int          octave_at, slot_at;

  note_beat_t  pending_notes[$];
  int          err_count, beats_sent, notes_seen, phases_run;

  function automatic int unsigned ticks_for(int unsigned idx);
    int unsigned tbl [17] = '{192, 144, 96, 72, 64, 48, 36, 32, 24, 16, 12, 8,
                              6, 4, 3, 2, 1};
    return tbl[idx > 16 ? 16 : idx];
  endfunction

  function automatic int span_now();
    return reg_span == 0 ? 1 : int'(reg_span);
  endfunction

  function automatic void walk_restart();
    if (!walk_down) begin
      octave_at = 0;
      slot_at = 0;
    end else begin
      slot_at = stack_n - 1;
      octave_at = span_now() - 1;
    end
  endfunction

  function automatic void walk_advance();
    int  span;
    bit  wrapped;
    span = span_now();
    wrapped = 0;
    if (stack_n <= 0 || reg_dir == DIR_RANDOM) return;
    slot_at += walk_down ? -1 : 1;
    if (slot_at >= stack_n) begin
      slot_at = 0;
      wrapped = 1;
    end else if (slot_at < 0) begin
      slot_at = stack_n - 1;
      wrapped = 1;
    end
    if (wrapped) begin
      octave_at += walk_down ? -1 : 1;
      if (octave_at >= span || octave_at < 0) begin
        if (reg_dir == DIR_UPDOWN) begin
          walk_down = !walk_down;
          walk_restart();
          if (stack_n > 1 || span > 1) walk_advance();
        end else begin
          walk_restart();
        end
      end
    end
  endfunction

  function automatic void stack_press(logic [6:0] key, logic [6:0] vel);
    int pos;
    for (int i = 0; i < stack_n; i++)
      if (stack_q[i][13:7] == key) begin
        stack_q[i] = {key, vel};
        return;
      end
    if (stack_n >= NOTE_SLOTS) return;
    pos = 0;
    while (pos < stack_n && stack_q[pos][13:7] < key) pos++;
    for (int i = stack_n; i > pos; i--) stack_q[i] = stack_q[i-1];
    stack_q[pos] = {key, vel};
    stack_n++;
  endfunction

  function automatic void stack_release(logic [6:0] key);
    for (int i = 0; i < stack_n; i++)
      if (stack_q[i][13:7] == key) begin
        for (int j = i; j + 1 < stack_n; j++) stack_q[j] = stack_q[j+1];
        stack_n--;
        return;
      end
  endfunction

  function automatic void arp_write_reg(cfg_idx_t idx, int unsigned val);
    case (idx)
      CFG_CHANNEL:  reg_chan = val & 'hf;
      CFG_DIR: begin
        reg_dir = val & 'h3;
        walk_down = (reg_dir == DIR_DOWN);
        walk_restart();
      end
      CFG_SPAN:     reg_span = val & 'h7;
      CFG_RHYTHM:   reg_rhythm = val & 'hffff;
      CFG_DIVISION: reg_div = val & 'h1f;
      CFG_GATE:     reg_gate = val & 'h1f;
      default: ;
    endcase
  endfunction

  // Returns 1 when the beat plays a note; the note-on comes back in nb.
  function automatic bit arp_apply(midi_row_t r, output note_beat_t nb);
    int unsigned presc, note;
    int          idx, span;
    logic [13:0] entry;
    bit          hit;
    presc = ticks_for(reg_div);
    hit = 0;
    nb = '0;
    case (r.cmd)
      CMD_TICK: if (playing) begin
        prescale_cnt = prescale_cnt + 8'd1;
        if (prescale_cnt >= presc) begin
          prescale_cnt = 0;
          if (stack_n > 0 && (rhythm_bit & reg_rhythm[15:0]) != 0) begin
            idx = (slot_at >= 0 && slot_at < stack_n) ? slot_at : 0;  // repair
            entry = stack_q[idx];
            note = entry[13:7] + 12 * (octave_at < 0 ? 0 : octave_at);
            while (note > 127) note -= 12;
            nb.note = note[6:0];
            nb.vel  = entry[6:0];
            nb.gate = 8'(ticks_for(reg_gate) - 1);
            hit = 1;
            if (reg_dir == DIR_RANDOM) begin
              span = span_now();
              octave_at = int'(r.rnd[3:0]) % span;
              slot_at   = int'(r.rnd[7:4]) % stack_n;
            end else begin
              walk_advance();
            end
          end
          rhythm_bit = rhythm_bit << 1;
          if (rhythm_bit == 0) rhythm_bit = 16'd1;
        end
      end
      CMD_START: begin
        playing = 1;
        rhythm_bit = 16'd1;
        prescale_cnt = 8'(presc - 1);
        walk_down = (reg_dir == DIR_DOWN);
        walk_restart();
      end
      CMD_CONTINUE: playing = 1;
      CMD_STOP:     playing = 0;
      CMD_NOTE_ON:  if (r.chan == reg_chan) stack_press(r.key, r.vel);
      CMD_NOTE_OFF: if (r.chan == reg_chan && !sustain) stack_release(r.key);
      CMD_CC: if (r.chan == reg_chan && r.ccn == PEDAL_CC) begin
        if (sustain && r.ccv == 0) stack_n = 0;
        sustain = (r.ccv != 0);
      end
      default: ;
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts with random gaps
  // ---------------------------------------------------------------------------
  int  burst_left;
  bit  hold_req;

  task automatic send_beat(midi_row_t r);
    note_beat_t nb;
    bit         hit;
    if (burst_left == 0) begin
      @(negedge clk);
      s_axis_tvalid = 0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tuser  = r.cmd;
    // chan, key, strike, controller, value, random byte (low bits first)
    s_axis_tdata  = {r.rnd, r.ccv, r.ccn, r.vel, r.key, r.chan};
    do @(posedge clk); while (!s_axis_tready);
    hit = arp_apply(r, nb);
    if (r.typed) begin
      pending_notes.push_back(r.want);
    end else if (hit) begin
      pending_notes.push_back(nb);
    end
    beats_sent++;
  endtask

  // Registers only change once the block is idle.
  task automatic write_regs(int unsigned vals [6]);
    @(negedge clk);
    s_axis_tvalid = 0;
    burst_left = 0;
    wait (pending_notes.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we = 1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = CFG_DATA_W'(vals[i]);
      arp_write_reg(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we = 0;
  endtask

  function automatic midi_row_t mk(logic [2:0] c, logic [3:0] ch, logic [6:0] k,
                                   logic [6:0] v, logic [6:0] n, logic [6:0] cv,
                                   logic [7:0] rb);
    midi_row_t r;
    r = '{cmd: c, chan: ch, key: k, vel: v, ccn: n, ccv: cv, rnd: rb,
          typed: 0, want: '0};
    return r;
  endfunction

  function automatic midi_row_t random_beat();
    midi_row_t   r;
    int unsigned pick;
    r = mk(CMD_TICK, ($urandom_range(0, 4) != 0) ? reg_chan[3:0] : 4'($urandom),
           7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
    // a small pool of keys makes repeats and matching note-offs common
    if ($urandom_range(0, 1)) r.key = 7'(36 + 5 * $urandom_range(0, 9));
    pick = $urandom_range(0, 99);
    if (pick < 48)      r.cmd = CMD_TICK;
    else if (pick < 73) r.cmd = CMD_NOTE_ON;
    else if (pick < 85) r.cmd = CMD_NOTE_OFF;
    else if (pick < 92) begin
      r.cmd = CMD_CC;
      if ($urandom_range(0, 2) != 0) r.ccn = PEDAL_CC;
      if ($urandom_range(0, 1)) r.ccv = 0;
    end
    else if (pick < 95) r.cmd = CMD_START;
    else if (pick < 97) r.cmd = CMD_CONTINUE;
    else if (pick < 99) r.cmd = CMD_STOP;
    else                r.cmd = CMD_UNUSED;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  int rx_mode, rx_age, hold_left;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (++rx_age >= 64) begin
      rx_age = 0;
      rx_mode = $urandom_range(0, 2);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready = 1;
        1:       m_axis_tready = $urandom_range(0, 1);
        default: m_axis_tready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    note_beat_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[21:0];
      notes_seen++;
      if (pending_notes.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected note-on beat %h", got);
      end else begin
        want = pending_notes.pop_front();
        if (got.note !== want.note || got.vel !== want.vel || got.gate !== want.gate) begin
          err_count++;
          if (err_count <= 10)
            $display("note-on %0d: note %0d/%0d vel %0d/%0d gate %0d/%0d (exp/got)",
                     notes_seen, want.note, got.note, want.vel, got.vel,
                     want.gate, got.gate);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    midi_row_t   dir_rows [$];
    midi_row_t   r;
    int unsigned vals [6];
    int unsigned spans [8] = '{1, 4, 0, 7, 2, 3, 1, 4};

    reg_chan = 0; reg_dir = DIR_UP; reg_span = 1; reg_rhythm = 'hffff;
    reg_div = 12; reg_gate = 14;
    stack_n = 0; prescale_cnt = 0; rhythm_bit = 16'd1;
    playing = 0; walk_down = 0; sustain = 0; octave_at = 0; slot_at = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset settings give 6 ticks per step and a gate of 3 ticks,
    // so the first tick after start plays the lowest held note.
    dir_rows.push_back(mk(CMD_NOTE_ON, 0, 60, 100, 0, 0, 0));
    dir_rows.push_back(mk(CMD_START, 0, 0, 0, 0, 0, 0));
    r = mk(CMD_TICK, 0, 0, 0, 0, 0, 8'hff);
    r.typed = 1;
    r.want = '{gate: 8'd2, vel: 7'd100, note: 7'd60};
    dir_rows.push_back(r);
    dir_rows.push_back(mk(CMD_NOTE_ON, 0, 127, 127, 127, 127, 8'hff));
    dir_rows.push_back(mk(CMD_NOTE_ON, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_NOTE_ON, 0, 60, 1, 0, 0, 0));      // repeat: velocity only
    dir_rows.push_back(mk(CMD_NOTE_ON, 15, 90, 50, 0, 0, 0));    // other channel
    dir_rows.push_back(mk(CMD_NOTE_OFF, 0, 50, 0, 0, 0, 0));     // unknown key
    dir_rows.push_back(mk(CMD_CC, 0, 0, 0, PEDAL_CC, 127, 0));   // pedal down
    dir_rows.push_back(mk(CMD_NOTE_OFF, 0, 127, 0, 0, 0, 0));    // held by pedal
    for (int i = 0; i < 7; i++) dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_CC, 0, 0, 0, 63, 0, 0));           // not the pedal
    dir_rows.push_back(mk(CMD_CC, 0, 0, 0, PEDAL_CC, 0, 0));     // release empties
    dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_NOTE_ON, 0, 127, 127, 0, 0, 0));
    dir_rows.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0));          // stopped: silent
    dir_rows.push_back(mk(CMD_UNUSED, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_CONTINUE, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // Random phases; the first few pin the register extremes.
    for (int ph = 0; ph < 12; ph++) begin
      vals[CFG_CHANNEL]  = (ph == 0) ? 0 : (ph == 1) ? 15 : $urandom_range(0, 15);
      vals[CFG_DIR]      = ph % 4;
      vals[CFG_SPAN]     = (ph < 8) ? spans[ph] : $urandom_range(1, 4);
      vals[CFG_RHYTHM]   = (ph == 0) ? 'hffff : (ph == 1) ? 0 : (ph == 2) ? 'h0001 :
                           (ph == 3) ? 'h8000 : $urandom_range(0, 'hffff) | 'h1111;
      vals[CFG_DIVISION] = (ph == 4) ? 0 : (ph == 5) ? 31 : (ph == 6) ? 16 :
                           $urandom_range(10, 20);
      vals[CFG_GATE]     = (ph == 0) ? 0 : (ph == 1) ? 31 : (ph == 2) ? 16 :
                           $urandom_range(0, 20);
      write_regs(vals);
      phases_run++;
      send_beat(mk(CMD_START, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 128; i++) begin
        if (ph == 7 && i == 10) hold_req = 1;  // block fills while output is held
        send_beat(random_beat());
      end
    end

    @(negedge clk);
    s_axis_tvalid = 0;
    wait (pending_notes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d MIDI/clock beats over %0d register settings, %0d note-ons checked",
             beats_sent, phases_run, notes_seen);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", err_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
